// ===== rtl/frd_pkg.sv =====
package frd_pkg;

    localparam int DEF_BUF_DEPTH = 1024;
    localparam int DEF_HEAD_LEN  = 12;
    localparam int MAX_RES       = 64;

    localparam int AMT_W   = 11;
    localparam int BACK_W  = 10;
    localparam int TOTAL_W = 17;
    localparam int TDATA_W = 24;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] END_BYTE   = 8'h16;

    localparam int DATA_CAP     = 300;
    localparam int UPG_CAP      = 267;
    localparam int UPG_EXTRA    = 11;
    localparam int UPG_HDR_NEED = 9;
    localparam int UPG_LEN_POS  = 7;

    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'hA001;
    localparam logic [7:0]  CRC8_POLY  = 8'h07;

    typedef enum logic [1:0] {
        EV_ACCEPT   = 2'd0,
        EV_DROP     = 2'd1,
        EV_NO_START = 2'd2,
        EV_OVERFLOW = 2'd3
    } event_t;

    typedef struct packed {
        event_t              code;
        logic [AMT_W-1:0]    amount;
        logic [BACK_W-1:0]   start_back;
    } evt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_HDR_CHK,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_LEN_CHK,
        ST_END_CHK,
        ST_CRC_RD,
        ST_CRC_UPD,
        ST_CK_RD1,
        ST_CK_RD2,
        ST_CK_CMP,
        ST_ACCEPT,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/frd_mem.sv =====
module frd_mem #(
    parameter int DEPTH = frd_pkg::DEF_BUF_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/frd_crc.sv =====
module frd_crc (
    input  logic        mode,
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import frd_pkg::*;

    always_comb
    begin
        logic [15:0] c16;
        logic [7:0]  c8;
        c16 = crc_in ^ {8'h00, data};
        c8  = crc_in[7:0] ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c16 = c16[0] ? ((c16 >> 1) ^ CRC16_POLY) : (c16 >> 1);
            c8  = c8[7] ? ((c8 << 1) ^ CRC8_POLY) : (c8 << 1);
        end
        crc_out = mode ? {8'h00, c8} : c16;
    end

endmodule

// ===== rtl/frame_resync_deframer_core.sv =====
// Channel  Direction  Beat contents
// s_*      in         tdata[7:0] data_byte
// m_*      out        tdata event_res, amount, start_back; tlast last_event; tuser events_lost
// cfg_*    in         cfg_data upgrade_mode
//
// A byte is written into the buffer, and the scan then restarts. It reads and compares each
// buffered byte in turn until it finds a start byte, checks the header, length and end byte,
// reads and folds in each byte covered by the check sum, then compares it and reports the frame.
// A drop restarts the scan at once, and a closing step hands over the last event.
// All reads go through the one read port of the byte buffer, which sets the pace.
// Reset clears only the control state; the buffer needs no clearing pass.
// A full output register stalls the scan only when an event already waits behind it.
// Input and configuration beats are taken only between bytes.
module frame_resync_deframer_core #(
    parameter int BUF_DEPTH = frd_pkg::DEF_BUF_DEPTH,
    parameter int HEAD_LEN  = frd_pkg::DEF_HEAD_LEN
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // data_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [frd_pkg::TDATA_W-1:0] m_tdata,   // event_res, amount, start_back, zero pad
    output logic                        m_tlast,
    output logic                        m_tuser,   // events_lost
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import frd_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int FW = $clog2(BUF_DEPTH + 1);
    localparam int XW = TOTAL_W + 1;
    localparam int CW = $clog2(MAX_RES + 1);

    state_t             state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [FW-1:0]      off_reg, off_next;
    logic [7:0]         len_lo_reg, len_lo_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] idx_reg, idx_next;
    logic [15:0]        crc_reg, crc_next;
    logic [7:0]         ck_lo_reg, ck_lo_next;
    logic               pend_v_reg, pend_v_next;
    evt_t               pend_reg, pend_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               lost_reg, lost_next;
    logic               out_v_reg, out_v_next;
    evt_t               out_reg, out_next;
    logic               out_last_reg, out_last_next;
    logic               out_lost_reg, out_lost_next;
    logic               mode_reg;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    logic [15:0]   crc_new;

    logic          hold, up, do_drop, ev_req;
    logic [FW-1:0] drop_n;
    evt_t          ev;
    logic [XW-1:0] off_x, fill_x, total_x, need_x, lo_pos_x, extra_x, cap_x, limit_x;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [FW-1:0] ofs);
        logic [FW:0] s;
        s = (FW+1)'(base) + (FW+1)'(ofs);
        if (s >= (FW+1)'(BUF_DEPTH))
        begin
            s = s - (FW+1)'(BUF_DEPTH);
        end
        return AW'(s);
    endfunction

    frd_mem #(
        .DEPTH(BUF_DEPTH),
        .AW   (AW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(s_tdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    frd_crc u_crc (
        .mode   (up),
        .crc_in (crc_reg),
        .data   (mem_rdata),
        .crc_out(crc_new)
    );

    assign up        = mode_reg;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = {1'b0, out_reg.start_back, out_reg.amount, out_reg.code};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_lost_reg;

    assign off_x    = XW'(off_reg);
    assign fill_x   = XW'(fill_reg);
    assign total_x  = XW'(total_reg);
    assign need_x   = up ? XW'(UPG_HDR_NEED) : XW'(HEAD_LEN);
    assign lo_pos_x = up ? XW'(UPG_LEN_POS) : XW'(HEAD_LEN - 2);
    assign extra_x  = up ? XW'(UPG_EXTRA) : XW'(HEAD_LEN + 3);
    assign cap_x    = up ? XW'(UPG_CAP) : XW'(DATA_CAP);
    assign limit_x  = up ? total_x - XW'(2) : total_x - XW'(3);

    always_comb
    begin
        hold = 1'b0;
        if (pend_v_reg && out_v_reg && !m_tready)
        begin
            case (state_reg)
                ST_FIND_CHK, ST_HDR_CHK, ST_LEN_CHK, ST_END_CHK,
                ST_CK_CMP, ST_ACCEPT, ST_FINISH: hold = 1'b1;
                default: hold = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        off_next      = off_reg;
        len_lo_next   = len_lo_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        ck_lo_next    = ck_lo_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        lost_next     = lost_reg;
        out_v_next    = out_v_reg && !m_tready;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        out_lost_next = out_lost_reg;
        mem_we        = 1'b0;
        mem_waddr     = wrap_add(head_reg, fill_reg);
        mem_re        = 1'b0;
        mem_raddr     = '0;
        do_drop       = 1'b0;
        drop_n        = '0;
        ev_req        = 1'b0;
        ev.code       = EV_ACCEPT;
        ev.amount     = '0;
        ev.start_back = '0;

        if (!hold)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (fill_reg == FW'(BUF_DEPTH))
                        begin
                            ev_req     = 1'b1;
                            ev.code    = EV_OVERFLOW;
                            ev.amount  = AMT_W'(fill_reg);
                            fill_next  = '0;
                            head_next  = '0;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            fill_next  = fill_reg + FW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    off_next   = '0;
                    state_next = (fill_reg == '0) ? ST_FINISH : ST_FIND_RD;
                end
                ST_FIND_RD:
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wrap_add(head_reg, off_reg);
                    state_next = ST_FIND_CHK;
                end
                ST_FIND_CHK:
                begin
                    if (mem_rdata == START_BYTE)
                    begin
                        state_next = ST_HDR_CHK;
                    end
                    else if (off_reg + FW'(1) == fill_reg)
                    begin
                        ev_req     = 1'b1;
                        ev.code    = EV_NO_START;
                        ev.amount  = AMT_W'(fill_reg);
                        fill_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        off_next   = off_reg + FW'(1);
                        state_next = ST_FIND_RD;
                    end
                end
                ST_HDR_CHK:
                begin
                    if (off_x + need_x > fill_x)
                    begin
                        if (off_reg == '0)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            do_drop = 1'b1;
                            drop_n  = off_reg;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = wrap_add(head_reg, FW'(off_x + lo_pos_x));
                        state_next = ST_LEN_LO;
                    end
                end
                ST_LEN_LO:
                begin
                    len_lo_next = mem_rdata;
                    mem_re      = 1'b1;
                    mem_raddr   = wrap_add(head_reg, FW'(off_x + lo_pos_x + XW'(1)));
                    state_next  = ST_LEN_HI;
                end
                ST_LEN_HI:
                begin
                    total_next = TOTAL_W'(XW'({mem_rdata, len_lo_reg}) + extra_x);
                    state_next = ST_LEN_CHK;
                end
                ST_LEN_CHK:
                begin
                    if (total_x > cap_x)
                    begin
                        do_drop = 1'b1;
                        drop_n  = off_reg + FW'(1);
                    end
                    else if (off_x + total_x > fill_x)
                    begin
                        if (off_reg == '0)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            do_drop = 1'b1;
                            drop_n  = off_reg;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = wrap_add(head_reg, FW'(off_x + total_x - XW'(1)));
                        state_next = ST_END_CHK;
                    end
                end
                ST_END_CHK:
                begin
                    if (mem_rdata != END_BYTE)
                    begin
                        do_drop = 1'b1;
                        drop_n  = off_reg + FW'(1);
                    end
                    else
                    begin
                        crc_next   = up ? 16'h0000 : CRC16_INIT;
                        idx_next   = TOTAL_W'(1);
                        state_next = ST_CRC_RD;
                    end
                end
                ST_CRC_RD:
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wrap_add(head_reg, FW'(off_x + XW'(idx_reg)));
                    state_next = ST_CRC_UPD;
                end
                ST_CRC_UPD:
                begin
                    crc_next   = crc_new;
                    idx_next   = idx_reg + TOTAL_W'(1);
                    state_next = (XW'(idx_reg) + XW'(1) == limit_x) ? ST_CK_RD1 : ST_CRC_RD;
                end
                ST_CK_RD1:
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wrap_add(head_reg, FW'(off_x + limit_x));
                    state_next = ST_CK_RD2;
                end
                ST_CK_RD2:
                begin
                    ck_lo_next = mem_rdata;
                    mem_re     = 1'b1;
                    mem_raddr  = wrap_add(head_reg, FW'(off_x + total_x - XW'(2)));
                    state_next = ST_CK_CMP;
                end
                ST_CK_CMP:
                begin
                    if (up ? (crc_reg[7:0] != ck_lo_reg) : (crc_reg != {mem_rdata, ck_lo_reg}))
                    begin
                        do_drop = 1'b1;
                        drop_n  = off_reg + FW'(1);
                    end
                    else if (off_reg != '0)
                    begin
                        ev_req     = 1'b1;
                        ev.code    = EV_DROP;
                        ev.amount  = AMT_W'(off_reg);
                        head_next  = wrap_add(head_reg, off_reg);
                        fill_next  = fill_reg - off_reg;
                        off_next   = '0;
                        state_next = ST_ACCEPT;
                    end
                    else
                    begin
                        state_next = ST_ACCEPT;
                    end
                end
                ST_ACCEPT:
                begin
                    ev_req        = 1'b1;
                    ev.code       = EV_ACCEPT;
                    ev.amount     = AMT_W'(total_reg);
                    ev.start_back = BACK_W'(fill_reg - FW'(1));
                    head_next     = wrap_add(head_reg, FW'(total_reg));
                    fill_next     = fill_reg - FW'(total_reg);
                    state_next    = ST_SCAN;
                end
                ST_FINISH:
                begin
                    if (pend_v_reg)
                    begin
                        out_v_next    = 1'b1;
                        out_next      = pend_reg;
                        out_last_next = 1'b1;
                        out_lost_next = lost_reg;
                    end
                    pend_v_next = 1'b0;
                    cnt_next    = '0;
                    lost_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end

        if (do_drop)
        begin
            ev_req     = 1'b1;
            ev.code    = EV_DROP;
            ev.amount  = AMT_W'(drop_n);
            head_next  = wrap_add(head_reg, drop_n);
            fill_next  = fill_reg - drop_n;
            state_next = ST_SCAN;
        end

        if (ev_req)
        begin
            if (cnt_reg < CW'(MAX_RES))
            begin
                if (pend_v_reg)
                begin
                    out_v_next    = 1'b1;
                    out_next      = pend_reg;
                    out_last_next = 1'b0;
                    out_lost_next = 1'b0;
                end
                pend_v_next = 1'b1;
                pend_next   = ev;
                cnt_next    = cnt_reg + CW'(1);
            end
            else
            begin
                lost_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            fill_reg   <= '0;
            pend_v_reg <= 1'b0;
            cnt_reg    <= '0;
            lost_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
            mode_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            pend_v_reg <= pend_v_next;
            cnt_reg    <= cnt_next;
            lost_reg   <= lost_next;
            out_v_reg  <= out_v_next;
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        len_lo_reg   <= len_lo_next;
        total_reg    <= total_next;
        idx_reg      <= idx_next;
        crc_reg      <= crc_next;
        ck_lo_reg    <= ck_lo_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        out_lost_reg <= out_lost_next;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(BUF_DEPTH))
        else $error("fill count above buffer depth");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_RES))
        else $error("event count above limit");
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_v_reg && cnt_reg == '0 && !lost_reg)
        else $error("event state left over at idle");
    a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> cnt_reg != '0)
        else $error("held event not counted");
`endif

endmodule
